// ===== rtl/text_console_scroll_buffer_macros.svh =====
// Assertion helpers shared by the console buffer modules.
// Each module that uses them has i_clk and i_rst_n in scope.
`ifndef TEXT_CONSOLE_SCROLL_BUFFER_MACROS_SVH
`define TEXT_CONSOLE_SCROLL_BUFFER_MACROS_SVH

// Same-cycle implication.
`define TCSB_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TCSB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tcsb_pkg.sv =====
package tcsb_pkg;

    localparam int DEF_ROWS = 24;
    localparam int DEF_COLS = 80;

    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_CR = 8'd13;

    // controller -> datapath
    typedef struct packed {
        logic latch;
        logic scroll;
        logic clear;
        logic sweep_start;
        logic sweep_step;
        logic access;
        logic rd_capture;
        logic load_out;
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       scroll_need;
        logic       cell_ok;
        logic       line_flagged;
        logic       sweep_last;
        logic       out_free;
    } t_dp_sts;

endpackage

// ===== rtl/text_console_scroll_buffer.sv =====
// Flow: decode, then a put past the last line scrolls; a put or write-at to a blank
//   line sweeps it to zero before writing; a read waits on the line store. Off-screen
//   write-at, clear and reads of blank or off-screen cells go straight to the result.
// One request in flight: the next is accepted after the result registers, which waits
//   on a free output; set by the single-port line store and the sweep of a blank line.
// Reset: synchronous, active low; cursor and ring pointer zero, every line marked blank.
module text_console_scroll_buffer #(
    parameter int ROWS = tcsb_pkg::DEF_ROWS,
    parameter int COLS = tcsb_pkg::DEF_COLS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // request side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] char_code, [12:8] cell_row, [19:13] cell_col
    input  logic [1:0]  s_axis_tuser,   // [1:0] command

    // result side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [7:0] read_char, [12:8] cursor_line,
                                        // [19:13] cursor_column, [20] did_scroll
);
    import tcsb_pkg::*;

    // Store is a ring of lines: a scroll just bumps the top-line pointer
    // and flags the recycled line blank. Clear flags every line. A flagged
    // line reads as zero and gets swept to zero before its first write.
    t_ctrl_cmd  cmd;
    t_dp_sts    sts;

    logic [7:0] read_char;
    logic [4:0] cursor_line;
    logic [6:0] cursor_column;
    logic       did_scroll;

    tcsb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    tcsb_dp #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_command       (s_axis_tuser),
        .i_char_code     (s_axis_tdata[7:0]),
        .i_cell_row      (s_axis_tdata[12:8]),
        .i_cell_col      (s_axis_tdata[19:13]),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .o_read_char     (read_char),
        .o_cursor_line   (cursor_line),
        .o_cursor_column (cursor_column),
        .o_did_scroll    (did_scroll)
    );

    assign m_axis_tdata = {3'b000, did_scroll, cursor_column, cursor_line, read_char};

endmodule

// ===== rtl/tcsb_ram.sv =====
module tcsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tcsb_ctrl.sv =====
`include "text_console_scroll_buffer_macros.svh"

module tcsb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  tcsb_pkg::t_dp_sts  i_sts,
    output tcsb_pkg::t_ctrl_cmd o_cmd
);
    import tcsb_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PREP   = 3'd1;
    localparam logic [2:0] ST_SWEEP  = 3'd2;
    localparam logic [2:0] ST_ACCESS = 3'd3;
    localparam logic [2:0] ST_RWAIT  = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_ctrl_cmd  cmd;

    assign o_req_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    cmd.latch = 1'b1;
                    n_state   = ST_PREP;
                end
            end
            ST_PREP: begin
                unique case (i_sts.cmd)
                    CMD_PUT: begin
                        if (i_sts.scroll_need) begin
                            cmd.scroll = 1'b1;
                        end else if (i_sts.line_flagged) begin
                            cmd.sweep_start = 1'b1;
                            n_state         = ST_SWEEP;
                        end else begin
                            n_state = ST_ACCESS;
                        end
                    end
                    CMD_WRITE: begin
                        if (!i_sts.cell_ok) begin
                            n_state = ST_DONE;
                        end else if (i_sts.line_flagged) begin
                            cmd.sweep_start = 1'b1;
                            n_state         = ST_SWEEP;
                        end else begin
                            n_state = ST_ACCESS;
                        end
                    end
                    CMD_READ: begin
                        // RAM address is already on the port; data lands next cycle
                        if (i_sts.cell_ok && !i_sts.line_flagged) begin
                            n_state = ST_RWAIT;
                        end else begin
                            n_state = ST_DONE;
                        end
                    end
                    default: begin
                        cmd.clear = 1'b1;
                        n_state   = ST_DONE;
                    end
                endcase
            end
            ST_SWEEP: begin
                cmd.sweep_step = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = ST_ACCESS;
                end
            end
            ST_ACCESS: begin
                cmd.access = 1'b1;
                n_state    = ST_DONE;
            end
            ST_RWAIT: begin
                cmd.rd_capture = 1'b1;
                n_state        = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    cmd.load_out = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd = cmd;

    `TCSB_ASSERT_NEXT(a_accept_to_prep, i_req_valid && o_req_ready, r_state == ST_PREP, "accept did not start a request")
    `TCSB_ASSERT_NEXT(a_sweep_exit, cmd.sweep_step && i_sts.sweep_last, r_state == ST_ACCESS, "line sweep did not end in access")
    `TCSB_ASSERT_NEXT(a_single_scroll, cmd.scroll, !cmd.scroll, "scroll issued twice for one put")

endmodule

// ===== rtl/tcsb_dp.sv =====
`include "text_console_scroll_buffer_macros.svh"

module tcsb_dp #(
    parameter int ROWS = tcsb_pkg::DEF_ROWS,
    parameter int COLS = tcsb_pkg::DEF_COLS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [1:0]          i_command,
    input  logic [7:0]          i_char_code,
    input  logic [4:0]          i_cell_row,
    input  logic [6:0]          i_cell_col,
    input  tcsb_pkg::t_ctrl_cmd i_cmd,
    output tcsb_pkg::t_dp_sts   o_sts,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [7:0]          o_read_char,
    output logic [4:0]          o_cursor_line,
    output logic [6:0]          o_cursor_column,
    output logic                o_did_scroll
);
    import tcsb_pkg::*;

    localparam int LW    = $clog2(ROWS + 1);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam int AW    = RW + CW;
    localparam int DEPTH = ROWS * (2 ** CW);

    // latched request
    logic [1:0]  r_cmd;
    logic [7:0]  r_ch;
    logic [4:0]  r_row;
    logic [6:0]  r_col;

    // cursor, ring pointer, per-line pending-clear flags
    logic [LW-1:0]   r_line;
    logic [CW-1:0]   r_ccol;
    logic [RW-1:0]   r_top;
    logic [ROWS-1:0] r_clr;
    logic [CW-1:0]   r_cnt;
    logic            r_scr;
    logic [7:0]      r_rd;

    logic            r_ovalid;
    logic [7:0]      r_o_rd;
    logic [4:0]      r_o_line;
    logic [6:0]      r_o_col;
    logic            r_o_scr;

    logic [RW-1:0] lrow;
    logic [CW-1:0] tcol;
    logic [RW:0]   psum;
    logic [RW-1:0] phys;
    logic          cell_ok;
    logic          newline;
    logic [AW-1:0] ram_addr;
    logic          ram_we;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;
    logic          cur_bottom;
    logic          cur_in_range;

    assign cell_ok = (32'(r_row) < ROWS) && (32'(r_col) < COLS);

    always_comb begin
        if (r_cmd == CMD_PUT) begin
            lrow = r_line[RW-1:0];
            tcol = r_ccol;
        end else begin
            lrow = RW'(r_row);
            tcol = CW'(r_col);
        end
    end

    // logical line -> physical line through the ring pointer
    assign psum = {1'b0, lrow} + {1'b0, r_top};
    assign phys = (psum >= (RW+1)'(ROWS)) ? RW'(psum - (RW+1)'(ROWS)) : psum[RW-1:0];

    assign newline = (r_ch == CH_LF) || (r_ch == CH_CR) || (r_ccol == CW'(COLS - 1));

    assign ram_we    = i_cmd.sweep_step || i_cmd.access;
    assign ram_wdata = i_cmd.sweep_step ? 8'd0 : r_ch;
    assign ram_addr  = i_cmd.sweep_step ? {phys, r_cnt} : {phys, tcol};

    tcsb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd <= i_command;
            r_ch  <= i_char_code;
            r_row <= i_cell_row;
            r_col <= i_cell_col;
            r_rd  <= 8'd0;
            r_scr <= 1'b0;
        end
        if (i_cmd.scroll) begin
            r_scr <= 1'b1;
        end
        if (i_cmd.rd_capture) begin
            r_rd <= ram_rdata;
        end
        if (i_cmd.sweep_start) begin
            r_cnt <= '0;
        end else if (i_cmd.sweep_step) begin
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.load_out) begin
            r_o_rd   <= r_rd;
            r_o_line <= 5'(r_line);
            r_o_col  <= 7'(r_ccol);
            r_o_scr  <= r_scr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line   <= '0;
            r_ccol   <= '0;
            r_top    <= '0;
            r_clr    <= '1;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_line <= '0;
                r_ccol <= '0;
                r_top  <= '0;
                r_clr  <= '1;
            end
            if (i_cmd.scroll) begin
                // old top line becomes the new bottom line, blank until swept
                r_top        <= (r_top == RW'(ROWS - 1)) ? '0 : r_top + 1'b1;
                r_clr[r_top] <= 1'b1;
                r_line       <= LW'(ROWS - 1);
                r_ccol       <= '0;
            end
            if (i_cmd.sweep_step && (r_cnt == CW'(COLS - 1))) begin
                r_clr[phys] <= 1'b0;
            end
            if (i_cmd.access && (r_cmd == CMD_PUT)) begin
                if (newline) begin
                    r_line <= r_line + 1'b1;
                    r_ccol <= '0;
                end else begin
                    r_ccol <= r_ccol + 1'b1;
                end
            end
            if (i_cmd.load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_sts.cmd          = r_cmd;
    assign o_sts.scroll_need  = (r_line >= LW'(ROWS));
    assign o_sts.cell_ok      = cell_ok;
    assign o_sts.line_flagged = r_clr[phys];
    assign o_sts.sweep_last   = (r_cnt == CW'(COLS - 1));
    assign o_sts.out_free     = !r_ovalid || i_out_ready;

    assign o_out_valid     = r_ovalid;
    assign o_read_char     = r_o_rd;
    assign o_cursor_line   = r_o_line;
    assign o_cursor_column = r_o_col;
    assign o_did_scroll    = r_o_scr;

    // cursor checks
    assign cur_bottom   = (r_line == LW'(ROWS - 1)) && (r_ccol == '0);
    assign cur_in_range = (r_line <= LW'(ROWS)) && (32'(r_ccol) < COLS);

    `TCSB_ASSERT_IMPL(a_access_line_clean, i_cmd.access, !r_clr[phys], "write to a blank line")
    `TCSB_ASSERT_NEXT(a_scroll_cursor, i_cmd.scroll, cur_bottom, "bad cursor after scroll")
    `TCSB_ASSERT_IMPL(a_cursor_range, 1'b1, cur_in_range, "cursor outside the screen")

endmodule

// ===== test/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tcsb_pkg::*;

    localparam int ROWS           = DEF_ROWS;
    localparam int COLS           = DEF_COLS;
    localparam int RANDOM_TARGET  = 800;
    // Cycles without any handshake before the run is declared hung. Worst legit
    // gap is one request in flight, including a full line sweep, plus a long tready stall.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 2 * (4 + COLS);

    // One request as the block sees it.
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] ch;
        logic [4:0] row;
        logic [6:0] col;
    } t_console_req;

    // One result: cell read back, cursor after the request, scroll flag.
    typedef struct packed {
        logic [7:0] read_char;
        logic [4:0] cursor_line;
        logic [6:0] cursor_column;
        logic       did_scroll;
    } t_console_result;

    bit          i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;   // [7:0] char_code, [12:8] cell_row, [19:13] cell_col
    logic [1:0]  s_axis_tuser  = '0;   // [1:0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // [7:0] read_char, [12:8] cursor_line,
                                       // [19:13] cursor_column, [20] did_scroll

    text_console_scroll_buffer #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Shadow copy of the screen and the teletype cursor.
    logic [7:0] screen [ROWS][COLS];
    int         cur_line;
    int         cur_col;

    t_console_req    pending_requests [$];   // waiting to be driven
    t_console_result expected_results [$];   // predicted, waiting on the output
    t_console_req    next_req;

    int  total_requests;
    int  req_count;
    int  results_checked;
    int  mismatch_count;
    int  stall_cycles;
    int  tx_idle_pct;
    int  rx_idle_pct;
    int  put_count, write_count, read_count, clear_count, scroll_count;
    bit  req_taken;

    // Advance the shadow console by one request and return what the block
    // should answer.
    function automatic t_console_result console_step(t_console_req r);
        t_console_result res;
        bit              cell_ok;
        int              y;
        int              x;
        res     = '0;
        cell_ok = (r.row < ROWS) && (r.col < COLS);
        case (r.cmd)
            CMD_PUT: begin
                // Cursor parked below the last line: shift everything up first.
                if (cur_line >= ROWS) begin
                    for (y = 0; y < ROWS - 1; y++)
                        for (x = 0; x < COLS; x++)
                            screen[y][x] = screen[y + 1][x];
                    for (x = 0; x < COLS; x++)
                        screen[ROWS - 1][x] = '0;
                    cur_line       = ROWS - 1;
                    cur_col        = 0;
                    res.did_scroll = 1'b1;
                end
                // LF and CR land in the cell too, then break the line.
                screen[cur_line][cur_col] = r.ch;
                if (r.ch == CH_LF || r.ch == CH_CR || cur_col == COLS - 1) begin
                    cur_line++;
                    cur_col = 0;
                end else begin
                    cur_col++;
                end
            end
            CMD_WRITE: begin
                if (cell_ok)
                    screen[r.row][r.col] = r.ch;
            end
            CMD_READ: begin
                if (cell_ok)
                    res.read_char = screen[r.row][r.col];
            end
            default: begin
                for (y = 0; y < ROWS; y++)
                    for (x = 0; x < COLS; x++)
                        screen[y][x] = '0;
                cur_line = 0;
                cur_col  = 0;
            end
        endcase
        res.cursor_line   = cur_line[4:0];
        res.cursor_column = cur_col[6:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < 20)
            $display("tb: mismatch on result %0d: %s got %0d, expected %0d",
                     results_checked, what, got, want);
        mismatch_count++;
    endtask

    task automatic queue_request(input logic [1:0] cmd, input logic [7:0] ch,
                                 input logic [4:0] row, input logic [6:0] col);
        t_console_req r;
        r.cmd = cmd;
        r.ch  = ch;
        r.row = row;
        r.col = col;
        pending_requests.push_back(r);
    endtask

    // Idle mix by thirds of the run: receiver-heavy stalls, then sender-heavy
    // gaps, then full rate in both directions.
    always_comb begin
        if (req_count * 3 < total_requests) begin
            tx_idle_pct = 32;
            rx_idle_pct = 60;
        end else if (req_count * 3 < 2 * total_requests) begin
            tx_idle_pct = 60;
            rx_idle_pct = 32;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    end

    // Request driver: updates on the falling edge; a request stays on the bus
    // until the rising edge that takes it.
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || req_taken)) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                next_req = pending_requests.pop_front();
                s_axis_tdata  <= {4'b0, next_req.col, next_req.row, next_req.ch};
                s_axis_tuser  <= next_req.cmd;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= i_rst_n && ($urandom_range(99) >= rx_idle_pct);
    end

    // Monitor: on each rising edge check the result side first, then predict
    // for any request taken on the same edge (one request in flight, so its
    // own result can never show up on that edge).
    always @(posedge i_clk) begin
        t_console_req    seen_req;
        t_console_result want;
        t_console_result got;
        if (!i_rst_n) begin
            req_taken = 1'b0;
        end else begin
            req_taken = s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[7:0], m_axis_tdata[12:8], m_axis_tdata[19:13],
                       m_axis_tdata[20]};
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing outstanding, tdata",
                                    m_axis_tdata, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.read_char != want.read_char)
                        report_mismatch("read_char", got.read_char, want.read_char);
                    if (got.cursor_line != want.cursor_line)
                        report_mismatch("cursor_line", got.cursor_line, want.cursor_line);
                    if (got.cursor_column != want.cursor_column)
                        report_mismatch("cursor_column", got.cursor_column,
                                        want.cursor_column);
                    if (got.did_scroll != want.did_scroll)
                        report_mismatch("did_scroll", got.did_scroll, want.did_scroll);
                end
                results_checked++;
            end
            if (req_taken) begin
                seen_req = {s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[12:8],
                            s_axis_tdata[19:13]};
                want = console_step(seen_req);
                expected_results.push_back(want);
                req_count++;
                case (seen_req.cmd)
                    CMD_PUT:   put_count++;
                    CMD_WRITE: write_count++;
                    CMD_READ:  read_count++;
                    default:   clear_count++;
                endcase
                if (want.did_scroll)
                    scroll_count++;
            end
            if (req_taken || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    // Hang detector.
    initial begin
        while (stall_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("tb: failure");
        $finish;
    end

    initial begin
        int kind;
        int len;
        int i;
        logic [7:0] ch;

        for (int y = 0; y < ROWS; y++)
            for (int x = 0; x < COLS; x++)
                screen[y][x] = '0;
        cur_line = 0;
        cur_col  = 0;

        // Directed opening: empty screen, byte extremes, both line breaks,
        // corner cells, out-of-range cells on each axis, clear.
        queue_request(CMD_READ,  8'h00, 5'd0,  7'd0);
        queue_request(CMD_PUT,   8'h41, 5'd0,  7'd0);
        queue_request(CMD_PUT,   8'hFF, 5'd0,  7'd0);
        queue_request(CMD_PUT,   8'h00, 5'd0,  7'd0);
        queue_request(CMD_PUT,   CH_LF, 5'd0,  7'd0);
        queue_request(CMD_PUT,   CH_CR, 5'd0,  7'd0);
        queue_request(CMD_WRITE, 8'hFF, 5'd0,  7'd0);
        queue_request(CMD_WRITE, 8'h80, 5'd23, 7'd79);
        queue_request(CMD_WRITE, 8'h11, 5'd24, 7'd0);
        queue_request(CMD_WRITE, 8'h22, 5'd0,  7'd80);
        queue_request(CMD_WRITE, 8'h55, 5'd31, 7'd127);
        queue_request(CMD_READ,  8'h00, 5'd0,  7'd0);
        queue_request(CMD_READ,  8'h00, 5'd23, 7'd79);
        queue_request(CMD_READ,  8'hFF, 5'd24, 7'd0);
        queue_request(CMD_READ,  8'h00, 5'd0,  7'd80);
        queue_request(CMD_READ,  8'h00, 5'd31, 7'd127);
        queue_request(CMD_READ,  8'h00, 5'd0,  7'd1);
        queue_request(CMD_READ,  8'h00, 5'd2,  7'd0);
        queue_request(CMD_CLEAR, 8'hAA, 5'd31, 7'd127);
        queue_request(CMD_READ,  8'h00, 5'd23, 7'd79);
        queue_request(CMD_PUT,   8'h78, 5'd0,  7'd0);
        queue_request(CMD_READ,  8'h00, 5'd0,  7'd0);

        // Random part: mostly text lines so the cursor walks down and scrolls,
        // mixed with cell reads and writes, a little noise and rare clears.
        len = pending_requests.size() + RANDOM_TARGET;
        while (pending_requests.size() < len) begin
            kind = $urandom_range(99);
            if (kind < 55) begin
                // Short lines most of the time; now and then a long one that can
                // wrap at the last column.
                i = ($urandom_range(9) == 0) ? $urandom_range(70, 90) : $urandom_range(1, 10);
                repeat (i - 1)
                    queue_request(CMD_PUT, 8'($urandom_range(255)), 5'($urandom_range(31)),
                                  7'($urandom_range(127)));
                case ($urandom_range(2))
                    0:       ch = CH_LF;
                    1:       ch = CH_CR;
                    default: ch = 8'($urandom_range(255));
                endcase
                queue_request(CMD_PUT, ch, 5'($urandom_range(31)), 7'($urandom_range(127)));
            end else if (kind < 75) begin
                if ($urandom_range(9) == 0)
                    queue_request(CMD_READ, 8'($urandom_range(255)), 5'($urandom_range(31)),
                                  7'($urandom_range(127)));
                else
                    queue_request(CMD_READ, 8'($urandom_range(255)), 5'($urandom_range(23)),
                                  7'($urandom_range(79)));
            end else if (kind < 91) begin
                if ($urandom_range(9) == 0)
                    queue_request(CMD_WRITE, 8'($urandom_range(255)), 5'($urandom_range(31)),
                                  7'($urandom_range(127)));
                else
                    queue_request(CMD_WRITE, 8'($urandom_range(255)), 5'($urandom_range(23)),
                                  7'($urandom_range(79)));
            end else if (kind < 99) begin
                case ($urandom_range(2))
                    0:       queue_request(CMD_PUT, 8'($urandom_range(255)),
                                           5'($urandom_range(31)), 7'($urandom_range(127)));
                    1:       queue_request(CMD_WRITE, 8'($urandom_range(255)),
                                           5'($urandom_range(31)), 7'($urandom_range(127)));
                    default: queue_request(CMD_READ, 8'($urandom_range(255)),
                                           5'($urandom_range(31)), 7'($urandom_range(127)));
                endcase
            end else begin
                queue_request(CMD_CLEAR, 8'($urandom_range(255)), 5'($urandom_range(31)),
                              7'($urandom_range(127)));
            end
        end
        total_requests = pending_requests.size();

        // Single reset at the start; released on a falling edge.
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: every request taken, every result back, then a quiet window
        // that would expose a stray extra result.
        while (pending_requests.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb: %0d requests (%0d put, %0d write-at, %0d read, %0d clear), %0d scrolls",
                 req_count, put_count, write_count, read_count, clear_count, scroll_count);
        $display("tb: %0d results compared, %0d field mismatches",
                 results_checked, mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== text_console_scroll_buffer.f =====
+incdir+rtl
rtl/tcsb_pkg.sv
rtl/tcsb_ram.sv
rtl/tcsb_ctrl.sv
rtl/tcsb_dp.sv
rtl/text_console_scroll_buffer.sv
test/testbench.sv
